[sv/tcfr_pkg.sv]
// Shared types and constants for the timing channel frame receiver.
package tcfr_pkg;

    // Interval measurement and threshold width.
    localparam int CNT_W = 20;
    // Data bits in one frame, and the frame with its parity bit.
    localparam int DATA_BITS = 8;
    localparam int FRAME_BITS = DATA_BITS + 1;
    // Counter of stored frame bits must reach FRAME_BITS itself.
    localparam int HELD_W = $clog2(FRAME_BITS + 1);
    localparam int BYTE_W = 8;
    localparam int PKT_W = 16;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = ((CNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((BYTE_W + PKT_W + 7) / 8) * 8;

    // Bit queue between the classifier and the frame logic.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    // Frame receiver states.
    typedef enum logic [1:0] {
        ST_HUNT,
        ST_FRAME,
        ST_HALT
    } frame_state_t;

    // One classified interval pushed from the front into the queue.
    typedef struct packed {
        logic push;
        logic bit_one;
    } bit_push_t;

    // One queued interval offered to the back.
    typedef struct packed {
        logic valid;
        logic bit_one;
    } bit_pop_t;

    // One received frame result.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              parity_ok;
        logic [PKT_W-1:0]  packet_number;
        logic              transfer_done;
    } frame_result_t;

endpackage

[sv/tcfr_front.sv]
// Front end: threshold register and interval-to-bit classification.
module tcfr_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tcfr_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic                          in_accept,
    input  logic [tcfr_pkg::CNT_W-1:0]    interval_count,
    output tcfr_pkg::bit_push_t           push
);
    import tcfr_pkg::*;

    localparam logic [CNT_W-1:0] THRESH_RESET = CNT_W'(20000);

    logic [CNT_W-1:0] busy_threshold_reg;

    // Threshold register; the user must write it only while the block is idle, which the block does not enforce.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_threshold_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            busy_threshold_reg <= cfg_wr_data;
        end
    end

    // A short interval means the channel was busy: that reads as a one.
    always_comb begin
        push.push    = in_accept;
        push.bit_one = (interval_count < busy_threshold_reg);
    end

endmodule

[sv/tcfr_queue.sv]
// Short bit queue between the classifier and the frame logic.
module tcfr_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcfr_pkg::bit_push_t  push,
    input  logic                 pop,
    output tcfr_pkg::bit_pop_t   head,
    output logic                 full
);
    import tcfr_pkg::*;

    logic [QUEUE_DEPTH-1:0]  bits_reg;
    logic [QUEUE_AW-1:0]     wr_ptr_reg;
    logic [QUEUE_AW-1:0]     rd_ptr_reg;
    logic [QUEUE_CW-1:0]     count_reg;
    logic                    do_pop;

    assign do_pop = pop && (count_reg != '0);

    // Storage is written at the tail only; no reset needed.
    always_ff @(posedge aclk) begin
        if (push.push) begin
            bits_reg[wr_ptr_reg] <= push.bit_one;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push.push && !do_pop) begin
                count_reg <= count_reg + QUEUE_CW'(1);
            end else if (!push.push && do_pop) begin
                count_reg <= count_reg - QUEUE_CW'(1);
            end
        end
    end

    // Head of the queue and fullness.
    always_comb begin
        head.valid   = (count_reg != '0);
        head.bit_one = bits_reg[rd_ptr_reg];
        full         = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    end

endmodule

[sv/tcfr_back.sv]
// Back end: frame assembly, parity check, packet count and output register.
module tcfr_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tcfr_pkg::bit_pop_t         head,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tcfr_pkg::frame_result_t    out_result
);
    import tcfr_pkg::*;

    frame_state_t             state_reg;
    frame_state_t             state_next;
    logic [HELD_W-1:0]        held_reg;
    logic [HELD_W-1:0]        held_next;
    logic [FRAME_BITS-1:0]    frame_reg;
    logic [FRAME_BITS-1:0]    frame_next;
    logic [PKT_W-1:0]         pkt_reg;
    logic [PKT_W-1:0]         pkt_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    frame_result_t            result_reg;
    frame_result_t            result_next;

    logic [FRAME_BITS-1:0]    frame_set;
    logic [HELD_W-1:0]        held_set;
    logic [DATA_BITS-1:0]     data_word;
    logic                     emit;

    // A bit is taken whenever the output register is free or being drained.
    assign pop = head.valid && (!out_valid_reg || out_ready);

    // Frame state, counters and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_HUNT;
            held_reg      <= '0;
            frame_reg     <= '0;
            pkt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            frame_reg     <= frame_next;
            pkt_reg       <= pkt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    // Frame with a one stored at the current bit position.
    always_comb begin
        frame_set = frame_reg;
        for (int i = 0; i < FRAME_BITS; i++) begin
            if (held_reg == HELD_W'(i)) begin
                frame_set[i] = 1'b1;
            end
        end
    end

    // Next state, frame close and result build.
    always_comb begin
        state_next     = state_reg;
        held_next      = held_reg;
        frame_next     = frame_reg;
        pkt_next       = pkt_reg;
        result_next    = result_reg;
        emit           = 1'b0;
        held_set       = held_reg;
        data_word      = frame_reg[DATA_BITS-1:0];

        // Output register drains when the sink takes the item.
        out_valid_next = out_valid_reg && !out_ready;

        if (pop) begin
            case (state_reg)
                ST_HUNT: begin
                    // A zero interval is the start bit; ones are idle line.
                    if (!head.bit_one) begin
                        state_next = ST_FRAME;
                    end
                end
                ST_FRAME: begin
                    if (!head.bit_one) begin
                        // Zeros count until the frame is full, then are ignored.
                        if (held_reg < HELD_W'(FRAME_BITS)) begin
                            held_next = held_reg + HELD_W'(1);
                        end
                    end else begin
                        if (held_reg < HELD_W'(FRAME_BITS)) begin
                            frame_next = frame_set;
                            held_set   = held_reg + HELD_W'(1);
                            held_next  = held_set;
                            data_word  = frame_set[DATA_BITS-1:0];
                        end
                        // The one that fills the last bit, or the first one that finds the frame full, closes it.
                        if (held_set == HELD_W'(FRAME_BITS)) begin
                            emit = 1'b1;
                        end
                    end
                end
                ST_HALT: begin
                    // Transfer ended: every later interval is dropped.
                end
                default: begin
                    state_next = ST_HUNT;
                end
            endcase
        end

        if (emit) begin
            result_next.data_byte = '0;
            for (int i = 0; i < BYTE_W; i++) begin
                if (i < DATA_BITS) begin
                    result_next.data_byte[i] = data_word[i];
                end
            end
            result_next.parity_ok     = ((^data_word) == frame_next[DATA_BITS]);
            result_next.packet_number = pkt_reg;
            result_next.transfer_done = (data_word == '0);
            out_valid_next            = 1'b1;
            held_next                 = '0;
            frame_next                = '0;
            if (data_word == '0) begin
                state_next = ST_HALT;
            end else begin
                state_next = ST_HUNT;
                pkt_next   = pkt_reg + PKT_W'(1);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

[sv/timing_channel_frame_receiver_unit.sv]
// Top level of the timing channel frame receiver.
//
// Each input item is one interval's loop-iteration count; a count below the
// busy threshold reads as a one, otherwise a zero. The receiver hunts for a
// zero start bit, stores eight data bits and an even-parity bit, and closes
// the frame on the first one-interval that fills the ninth bit or finds all
// nine bits held. Each closed frame yields one result item with the data
// byte, the parity check, and the packet number; an all-zero byte raises
// tlast, is not counted and halts the receiver until reset. One item is
// accepted every cycle while the queue is not full: the classifier pushes
// one bit per cycle into a four-entry queue, and the frame logic retires one
// bit per cycle into a single output register while that register is free or
// draining. A result held on m_tvalid stops the frame logic, and s_tready
// drops once the queue is full. The threshold is written through cfg_wr_en
// and cfg_wr_data; the user must do so only while the block is idle, which
// the block itself does not enforce.
module timing_channel_frame_receiver_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: busy threshold.
    input  logic                              cfg_wr_en,
    input  logic [tcfr_pkg::CNT_W-1:0]        cfg_wr_data,
    // Input intervals.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tcfr_pkg::S_TDATA_W-1:0]    s_tdata,  // [19:0] interval_count
    // Received frames.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tcfr_pkg::M_TDATA_W-1:0]    m_tdata,  // [7:0] data_byte, [23:8] packet_number
    output logic                              m_tuser,  // [0] parity_ok
    output logic                              m_tlast   // transfer_done
);
    import tcfr_pkg::*;

    bit_push_t      push;
    bit_pop_t       head;
    logic           pop;
    logic           queue_full;
    logic           in_accept;
    frame_result_t  result;

    assign s_tready  = !queue_full;
    assign in_accept = s_tvalid && !queue_full;

    // Classification of each interval.
    tcfr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_accept      (in_accept),
        .interval_count (s_tdata[CNT_W-1:0]),
        .push           (push)
    );

    // Bit queue between the two halves.
    tcfr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .full    (queue_full)
    );

    // Frame assembly and result output.
    tcfr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Result packing onto the stream.
    always_comb begin
        m_tdata = '0;
        m_tdata[BYTE_W-1:0]              = result.data_byte;
        m_tdata[BYTE_W+PKT_W-1:BYTE_W]   = result.packet_number;
        m_tuser = result.parity_ok;
        m_tlast = result.transfer_done;
    end

endmodule

[sim/timing_channel_frame_receiver_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the timing channel frame receiver with an in-line frame predictor.
module timing_channel_frame_receiver_unit_test;
    import tcfr_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] RESET_THRESHOLD = 20'd20000;

    // Tracks the receiver's frame state and holds the frames it must still emit.
    class frame_tracker;
        logic [CNT_W-1:0]      threshold;
        bit                    hunting;
        int unsigned           held;
        logic [FRAME_BITS-1:0] shift_bits;
        logic [PKT_W-1:0]      packets;
        bit                    halted;
        frame_result_t         pending_frames[$];
        int unsigned           mismatches;
        int unsigned           frames_seen;
        int unsigned           bad_parity;

        function new();
            threshold = RESET_THRESHOLD;
            hunting = 1'b1;
            held = 0;
            shift_bits = '0;
            packets = '0;
            halted = 1'b0;
            mismatches = 0;
            frames_seen = 0;
            bad_parity = 0;
        endfunction

        // A zero now would complete the data bits of the frame as all zeros.
        function bit zero_byte_ahead();
            return !halted && !hunting && held == DATA_BITS - 1 && shift_bits == '0;
        endfunction

        // Applies one accepted interval and queues the frame it closes, if any.
        function void take_interval(logic [CNT_W-1:0] count);
            logic [DATA_BITS-1:0] data;
            frame_result_t        res;
            if (halted) return;
            if (count >= threshold) begin
                if (hunting) hunting = 1'b0;
                else if (held < FRAME_BITS) held++;
                return;
            end
            if (!hunting && held < FRAME_BITS) begin
                shift_bits[held] = 1'b1;
                held++;
            end
            if (held != FRAME_BITS) return;
            data = shift_bits[DATA_BITS-1:0];
            res.data_byte = data[BYTE_W-1:0];
            res.parity_ok = ((^data) == shift_bits[DATA_BITS]);
            res.packet_number = packets;
            res.transfer_done = (data == '0);
            pending_frames.push_back(res);
            hunting = 1'b1;
            held = 0;
            shift_bits = '0;
            if (res.transfer_done) halted = 1'b1;
            else packets++;
        endfunction

        // Compares one emitted frame with the oldest predicted one.
        function void check_frame(logic [M_TDATA_W-1:0] tdata, logic tuser, logic tlast);
            frame_result_t got;
            frame_result_t want;
            got.data_byte = tdata[BYTE_W-1:0];
            got.packet_number = tdata[BYTE_W +: PKT_W];
            got.parity_ok = tuser;
            got.transfer_done = tlast;
            if (pending_frames.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected frame, actual data_byte %h parity_ok %b packet %0d done %b",
                         $time, got.data_byte, got.parity_ok, got.packet_number,
                         got.transfer_done);
                return;
            end
            want = pending_frames.pop_front();
            frames_seen++;
            if (!want.parity_ok) bad_parity++;
            if (got !== want) begin
                mismatches++;
                $display("%0t: frame mismatch, expected data_byte %h parity_ok %b packet %0d done %b",
                         $time, want.data_byte, want.parity_ok, want.packet_number,
                         want.transfer_done);
                $display("%0t: frame mismatch, actual   data_byte %h parity_ok %b packet %0d done %b",
                         $time, got.data_byte, got.parity_ok, got.packet_number,
                         got.transfer_done);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    frame_tracker tracker;
    bit           idle_on = 1'b1;
    int unsigned  sent = 0;
    int unsigned  idle_cycles = 0;

    timing_channel_frame_receiver_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Returns a count that reads as the given bit under the current threshold,
    // now and then right at the threshold boundary.
    function automatic logic [CNT_W-1:0] pick_count(bit one);
        int unsigned thr;
        thr = tracker.threshold;
        if (one && thr != 0) begin
            if ($urandom_range(0, 7) == 0) return CNT_W'(thr - 1);
            return CNT_W'($urandom_range(thr - 1, 0));
        end
        if ($urandom_range(0, 7) == 0) return CNT_W'(thr);
        return CNT_W'($urandom_range(CNT_MAX, thr));
    endfunction

    // Offers one interval and waits for its acceptance. Unless the count is to be
    // sent as given, a zero that would complete an all-zero data byte becomes a one,
    // so that the transfer only ends where intended.
    task automatic send_item(logic [CNT_W-1:0] count, bit as_given = 1'b0);
        if (!as_given && tracker.zero_byte_ahead() && count >= tracker.threshold
            && tracker.threshold != 0)
            count = pick_count(1'b1);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tdata <= S_TDATA_W'(count);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.take_interval(count);
        sent++;
    endtask

    // Sends ones until the receiver hunts for a start bit again.
    task automatic close_open_frame();
        while (!tracker.hunting && tracker.threshold != 0) send_item(pick_count(1'b1));
    endtask

    // Sends a whole frame: idle ones, start bit, data LSB first, parity bit, and
    // when the parity bit is a zero, some surplus zeros and a stop interval.
    task automatic send_frame(logic [DATA_BITS-1:0] data, bit parity_bit,
                              int unsigned lead, int unsigned extra);
        close_open_frame();
        repeat (lead) send_item(pick_count(1'b1));
        send_item(pick_count(1'b0));
        for (int i = 0; i < DATA_BITS; i++) send_item(pick_count(data[i]));
        send_item(pick_count(parity_bit));
        if (!parity_bit) begin
            repeat (extra) send_item(pick_count(1'b0));
            send_item(pick_count(1'b1));
        end
    endtask

    // Writes the threshold once every predicted frame is out and the block has settled.
    task automatic write_threshold(logic [CNT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (tracker.pending_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.threshold = value;
    endtask

    // Mostly well-formed frames with random content, plus noise and cut-off frames.
    task automatic random_burst();
        logic [DATA_BITS-1:0] data;
        bit                   parity_bit;
        case ($urandom_range(0, 9))
            0: begin
                repeat ($urandom_range(1, 6)) send_item(CNT_W'($urandom));
            end
            1: begin
                close_open_frame();
                send_item(pick_count(1'b0));
                repeat ($urandom_range(1, 7)) send_item(pick_count($urandom_range(0, 1)));
            end
            default: begin
                data = DATA_BITS'($urandom_range((1 << DATA_BITS) - 1, 1));
                parity_bit = ^data;
                if ($urandom_range(0, 4) == 0) parity_bit = !parity_bit;
                send_frame(data, parity_bit, $urandom_range(0, 2), $urandom_range(0, 2));
            end
        endcase
    endtask

    task automatic run_phase(logic [CNT_W-1:0] thr, int unsigned items);
        int unsigned stop_at;
        write_threshold(thr);
        stop_at = sent + items;
        while (sent < stop_at) random_burst();
    endtask

    // Result side: ready with random stall bursts while idling is enabled.
    initial begin
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Checks every accepted result item.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_frame(m_tdata, m_tuser, m_tlast);
    end

    // Ends the run when no item moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        tracker = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Ones while hunting are ignored; then a bad-parity frame closed by its
        // stop interval after a surplus zero.
        send_item('0);
        send_item(RESET_THRESHOLD - 1'b1);
        send_frame(8'hA4, 1'b0, 0, 1);
        // Good-parity frame closed by a one parity bit, using the extreme counts.
        send_item(CNT_MAX);
        for (int i = 0; i < DATA_BITS; i++) begin
            if (i == DATA_BITS - 1) send_item(RESET_THRESHOLD);
            else if (i % 2 == 1) send_item(RESET_THRESHOLD - 1'b1);
            else send_item('0);
        end
        send_item(RESET_THRESHOLD - 1'b1);

        // Random phases over several thresholds, the extremes among them.
        run_phase(20'd1, 250);
        close_open_frame();
        write_threshold('0);
        repeat (6) send_item(CNT_W'($urandom));
        run_phase(CNT_MAX, 250);
        run_phase(CNT_W'($urandom_range(64, 2)), 250);
        run_phase(CNT_W'($urandom_range(CNT_MAX, 1)), 300);
        idle_on = 1'b0;
        run_phase(RESET_THRESHOLD, 250);

        // All-zero byte ends the transfer; everything after it is ignored.
        close_open_frame();
        repeat (FRAME_BITS + 1) send_item(pick_count(1'b0), 1'b1);
        send_item(pick_count(1'b1), 1'b1);
        repeat (6) send_item(CNT_W'($urandom), 1'b1);
        s_tvalid <= 1'b0;

        while (tracker.pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run sent %0d intervals and checked %0d frames, %0d with a parity error,",
                 sent, tracker.frames_seen, tracker.bad_parity);
        $display("over thresholds from zero to full scale, ending with a halted transfer.");
        if (tracker.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
